/* src/frame_flip_grayscale_engine_macros.svh */
`ifndef FRAME_FLIP_GRAYSCALE_ENGINE_MACROS_SVH
`define FRAME_FLIP_GRAYSCALE_ENGINE_MACROS_SVH

// Check a same-cycle implication on clk_i, held off during reset
`define FFGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffge: same-cycle check failed");

// Check an implication in the next cycle on clk_i, held off during reset
`define FFGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffge: next-cycle check failed");

`endif

/* src/ffge_pkg.sv */
`timescale 1ns / 1ps

package ffge_pkg;

  // Frame geometry defaults
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Pixel format
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned PIXEL_BITS   = 3 * CHANNEL_BITS;

  // Configuration port
  localparam int unsigned CFG_BITS     = 9;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned MODE_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_GRAY       = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_VFLIP      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_HFLIP      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_GRAY_VFLIP = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_GRAY_HFLIP = 3'd4;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 9'd256;

  // Opcodes
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Divide-by-three through a reciprocal: sum * DIV3_MUL >> DIV3_SHIFT
  localparam int unsigned SUM_BITS   = CHANNEL_BITS + 2;
  localparam int unsigned DIV3_SHIFT = SUM_BITS + 2;
  localparam int unsigned DIV3_MUL   = (1 << DIV3_SHIFT) / 3 + 1;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Per-item control carried through the queue
  typedef struct packed {
    logic rd;
    logic gray;
    logic last;
  } ffge_ctl_t;

endpackage

/* src/ffge_ram.sv */
`timescale 1ns / 1ps

module ffge_ram #(
  parameter int unsigned WIDTH = ffge_pkg::PIXEL_BITS,
  parameter int unsigned DEPTH = ffge_pkg::MAX_WIDTH_DEF * ffge_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ffge_fifo.sv */
`timescale 1ns / 1ps

module ffge_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = ffge_pkg::QUEUE_DEPTH,
  localparam int unsigned PTR_BITS = $clog2(DEPTH),
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CNT_BITS'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/ffge_front.sv */
`timescale 1ns / 1ps

module ffge_front #(
  parameter int unsigned MAX_WIDTH  = ffge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ffge_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned WB = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HB = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned PW = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned EW = $bits(ffge_pkg::ffge_ctl_t) + PW + RW + CW
                               + ffge_pkg::PIXEL_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ffge_pkg::MODE_BITS-1:0]    mode_i,
  input  logic [WB-1:0]                     img_w_i,
  input  logic [HB-1:0]                     img_h_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] red_in_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] green_in_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] blue_in_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [EW-1:0]                     push_data_o
);

  import ffge_pkg::*;

  localparam int unsigned FB = WB + HB;

  logic [PW-1:0] load_pos_q, load_pos_d;
  logic [CW-1:0] read_col_q, read_col_d;
  logic [RW-1:0] read_row_q, read_row_d;

  logic          accept;
  logic          gray, vflip, hflip;
  logic [FB-1:0] frame_size;
  logic [PW-1:0] pos_cur;
  logic [FB-1:0] pos_inc;
  logic [CW-1:0] col_cur, src_col;
  logic [RW-1:0] row_cur, src_row;
  logic          col_end, row_end;
  ffge_ctl_t     ctl;

  assign accept       = in_valid_i & push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Decode transform mode; unused codes pass pixels through
  always_comb begin
    gray  = 1'b0;
    vflip = 1'b0;
    hflip = 1'b0;
    case (mode_i)
      MODE_GRAY:       gray = 1'b1;
      MODE_VFLIP:      vflip = 1'b1;
      MODE_HFLIP:      hflip = 1'b1;
      MODE_GRAY_VFLIP: begin
        gray  = 1'b1;
        vflip = 1'b1;
      end
      MODE_GRAY_HFLIP: begin
        gray  = 1'b1;
        hflip = 1'b1;
      end
      default: begin
        gray = 1'b0;
      end
    endcase
  end

  // Store position: restart if outside a shrunk frame, wrap at the end
  assign frame_size = FB'(img_w_i) * FB'(img_h_i);
  assign pos_cur    = (FB'(load_pos_q) >= frame_size) ? '0 : load_pos_q;
  assign pos_inc    = FB'(pos_cur) + FB'(1);

  // Read position: restart each coordinate that lies outside the frame
  assign col_cur = (WB'(read_col_q) >= img_w_i) ? '0 : read_col_q;
  assign row_cur = (HB'(read_row_q) >= img_h_i) ? '0 : read_row_q;
  assign col_end = (WB'(col_cur) == img_w_i - WB'(1));
  assign row_end = (HB'(row_cur) == img_h_i - HB'(1));

  // Mirror the source coordinates
  assign src_row = vflip ? RW'(img_h_i - HB'(1) - HB'(row_cur)) : row_cur;
  assign src_col = hflip ? CW'(img_w_i - WB'(1) - WB'(col_cur)) : col_cur;

  assign ctl.rd   = (opcode_i == OP_READ);
  assign ctl.gray = gray;
  assign ctl.last = row_end & col_end;

  assign push_data_o = {ctl, pos_cur, src_row, src_col, red_in_i, green_in_i, blue_in_i};

  // Advance the position of the accepted beat's kind
  always_comb begin
    load_pos_d = load_pos_q;
    read_col_d = read_col_q;
    read_row_d = read_row_q;
    if (accept) begin
      if (opcode_i == OP_STORE) begin
        load_pos_d = (pos_inc >= frame_size) ? '0 : PW'(pos_inc);
      end else begin
        read_col_d = col_end ? '0 : col_cur + CW'(1);
        if (col_end) begin
          read_row_d = row_end ? '0 : row_cur + RW'(1);
        end else begin
          read_row_d = row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      read_col_q <= '0;
      read_row_q <= '0;
    end else begin
      load_pos_q <= load_pos_d;
      read_col_q <= read_col_d;
      read_row_q <= read_row_d;
    end
  end

endmodule

/* src/ffge_back.sv */
`timescale 1ns / 1ps

module ffge_back #(
  parameter int unsigned MAX_WIDTH  = ffge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ffge_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned WB = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CW = $clog2(MAX_WIDTH),
  localparam int unsigned RW = $clog2(MAX_HEIGHT),
  localparam int unsigned PW = $clog2(MAX_WIDTH * MAX_HEIGHT),
  localparam int unsigned EW = $bits(ffge_pkg::ffge_ctl_t) + PW + RW + CW
                               + ffge_pkg::PIXEL_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [WB-1:0]                     img_w_i,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  logic [EW-1:0]                     pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] red_out_o,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] green_out_o,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] blue_out_o,
  output logic                              frame_last_o
);

  import ffge_pkg::*;

  localparam int unsigned MW = RW + WB;
  localparam int unsigned DW = SUM_BITS + DIV3_SHIFT;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  ffge_ctl_t             ctl_in, ctl_q;
  logic [PW-1:0]         pos_in, pos_q;
  logic [RW-1:0]         row_in, row_q;
  logic [CW-1:0]         col_in, col_q;
  logic [PIXEL_BITS-1:0] pix_in, pix_q;
  logic [PW-1:0]         addr_q;

  logic [MW-1:0]           row_base, rd_sum;
  logic                    ram_en, ram_we;
  logic [PIXEL_BITS-1:0]   ram_rdata;
  logic [CHANNEL_BITS-1:0] r_px, g_px, b_px, avg;
  logic [SUM_BITS-1:0]     sum;
  logic [DW-1:0]           div_prod;

  logic [CHANNEL_BITS-1:0] red_q, green_q, blue_q;
  logic                    last_q;

  assign {ctl_in, pos_in, row_in, col_in, pix_in} = pop_data_i;

  assign pop_ready_o = (state_q == ST_IDLE);

  // Linear address of the mirrored read
  assign row_base = MW'(row_q) * MW'(img_w_i);
  assign rd_sum   = row_base + MW'(col_q);

  assign ram_en = (state_q == ST_ACC);
  assign ram_we = ~ctl_q.rd;

  ffge_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (pix_q),
    .rdata_o (ram_rdata)
  );

  // Grayscale: truncated average of the three channels
  assign r_px     = ram_rdata[PIXEL_BITS-1 -: CHANNEL_BITS];
  assign g_px     = ram_rdata[2*CHANNEL_BITS-1 -: CHANNEL_BITS];
  assign b_px     = ram_rdata[CHANNEL_BITS-1:0];
  assign sum      = SUM_BITS'(r_px) + SUM_BITS'(g_px) + SUM_BITS'(b_px);
  assign div_prod = DW'(sum) * DW'(DIV3_MUL);
  assign avg      = div_prod[DIV3_SHIFT +: CHANNEL_BITS];

  // Sequence one command: fetch, address, memory access, and for a read the result
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: state_d = ST_ACC;
      ST_ACC:  state_d = ctl_q.rd ? ST_DATA : ST_IDLE;
      ST_DATA: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the command and its address
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      ctl_q <= ctl_in;
      pos_q <= pos_in;
      row_q <= row_in;
      col_q <= col_in;
      pix_q <= pix_in;
    end
    if (state_q == ST_ADDR) begin
      addr_q <= ctl_q.rd ? PW'(rd_sum) : pos_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DATA) begin
      red_q   <= ctl_q.gray ? avg : r_px;
      green_q <= ctl_q.gray ? avg : g_px;
      blue_q  <= ctl_q.gray ? avg : b_px;
      last_q  <= ctl_q.last;
    end
  end

  assign out_valid_o  = (state_q == ST_OUT);
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign frame_last_o = last_q;

endmodule

/* src/frame_flip_grayscale_engine.sv */
// Channel   Handshake                 Payload
// cfg       cfg_we_i                  cfg_idx_i, cfg_wdata_i
// in        in_valid_i / in_ready_o   opcode_i, red_in_i, green_in_i, blue_in_i
// out       out_valid_o / out_ready_i red_out_o, green_out_o, blue_out_o, frame_last_o
//
// Front computes positions, takes one beat per cycle into a two-entry queue unless full.
// The back serves one queued command at a time through the single pixel memory port:
// a store steps through address and access, a read also data and output, held on a stall.
// The read address needs a row times width multiply, registered before the memory access.
// Reset clears positions and control state at once; pixel memory and data are not cleared.
`timescale 1ns / 1ps
`include "frame_flip_grayscale_engine_macros.svh"

module frame_flip_grayscale_engine #(
  parameter int unsigned MAX_WIDTH  = ffge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ffge_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ffge_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ffge_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] red_in_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] green_in_i,
  input  logic [ffge_pkg::CHANNEL_BITS-1:0] blue_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] red_out_o,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] green_out_o,
  output logic [ffge_pkg::CHANNEL_BITS-1:0] blue_out_o,
  output logic                              frame_last_o
);

  import ffge_pkg::*;

  localparam int unsigned WB   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned EW   = $bits(ffge_ctl_t) + PW + RW + CW + PIXEL_BITS;
  localparam int unsigned CMPW = CFG_BITS + WB + HB;

  logic [MODE_BITS-1:0] mode_q;
  logic [CFG_BITS-1:0]  width_q, height_q;
  logic [WB-1:0]        img_w;
  logic [HB-1:0]        img_h;

  logic          q_push_valid, q_push_ready;
  logic [EW-1:0] q_push_data;
  logic          q_pop_valid, q_pop_ready;
  logic [EW-1:0] q_pop_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_GRAY;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_wdata_i[MODE_BITS-1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, large values as the maximum
  assign img_w = (width_q == '0) ? WB'(1) :
                 (CMPW'(width_q) > CMPW'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(width_q);
  assign img_h = (height_q == '0) ? HB'(1) :
                 (CMPW'(height_q) > CMPW'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(height_q);

  ffge_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .img_w_i      (img_w),
    .img_h_i      (img_h),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  ffge_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  ffge_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .img_w_i      (img_w),
    .pop_valid_i  (q_pop_valid),
    .pop_ready_o  (q_pop_ready),
    .pop_data_i   (q_pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_last_o (frame_last_o)
  );

  // The back never takes a new command while a result is pending
  `FFGE_ASSERT_NOW(a_no_pop_while_out, q_pop_valid && q_pop_ready, !out_valid_o)

  // A full queue stays full until the back drains an entry
  `FFGE_ASSERT_NEXT(a_full_holds, !in_ready_o && !(q_pop_valid && q_pop_ready), !in_ready_o)

  // A mode write lands in the mode register
  `FFGE_ASSERT_NEXT(a_mode_write, cfg_we_i && cfg_idx_i == REG_MODE,
                    mode_q == $past(cfg_wdata_i[MODE_BITS-1:0]))

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ffge_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // One transformed pixel as it leaves the block
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } out_pixel_t;

  // One frame setting for a stretch of traffic
  typedef struct {
    logic [CFG_BITS-1:0] mode_val;
    logic [CFG_BITS-1:0] width_val;
    logic [CFG_BITS-1:0] height_val;
    int unsigned         items;
  } frame_setup_t;

  // Frame store model: raster loads, mirrored reads, grayscale average
  class frame_scoreboard;
    logic [PIXEL_BITS-1:0] frame_mem [int unsigned];
    int unsigned           load_pos;
    int unsigned           rd_row;
    int unsigned           rd_col;
    logic [MODE_BITS-1:0]  mode;
    logic [CFG_BITS-1:0]   width_reg;
    logic [CFG_BITS-1:0]   height_reg;
    out_pixel_t            pending_px [$];
    int unsigned           errors;

    function new();
      load_pos   = 0;
      rd_row     = 0;
      rd_col     = 0;
      mode       = MODE_GRAY;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        REG_MODE:   mode = val[MODE_BITS-1:0];
        REG_WIDTH:  width_reg = val;
        REG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // Zero acts as one, anything above the maximum as the maximum
    function int unsigned frame_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned frame_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return height_reg;
    endfunction

    // Memory address of the next read, with stale coordinates restarted at zero
    function int unsigned source_addr();
      int unsigned w, h, row, col;
      w   = frame_w();
      h   = frame_h();
      row = (rd_row >= h) ? 0 : rd_row;
      col = (rd_col >= w) ? 0 : rd_col;
      if (mode == MODE_VFLIP || mode == MODE_GRAY_VFLIP) row = h - 1 - row;
      if (mode == MODE_HFLIP || mode == MODE_GRAY_HFLIP) col = w - 1 - col;
      return row * w + col;
    endfunction

    // A read may only go out when its source pixel has been stored
    function bit read_allowed();
      return frame_mem.exists(source_addr());
    endfunction

    function int unsigned outstanding();
      return pending_px.size();
    endfunction

    function void note_input(logic op, chan_t r, chan_t g, chan_t b);
      int unsigned w, h;
      logic [PIXEL_BITS-1:0] px;
      logic [SUM_BITS-1:0] sum;
      out_pixel_t res;
      w = frame_w();
      h = frame_h();
      if (op == OP_STORE) begin
        if (load_pos >= w * h) load_pos = 0;
        frame_mem[load_pos] = {r, g, b};
        load_pos++;
        if (load_pos >= w * h) load_pos = 0;
        return;
      end
      if (rd_col >= w) rd_col = 0;
      if (rd_row >= h) rd_row = 0;
      px = frame_mem[source_addr()];
      {res.red, res.green, res.blue} = px;
      if (mode == MODE_GRAY || mode == MODE_GRAY_VFLIP || mode == MODE_GRAY_HFLIP) begin
        sum = SUM_BITS'(res.red) + SUM_BITS'(res.green) + SUM_BITS'(res.blue);
        res.red   = chan_t'(sum / 3);
        res.green = res.red;
        res.blue  = res.red;
      end
      res.last = (rd_row == h - 1) && (rd_col == w - 1);
      pending_px.push_back(res);
      // Advance in raster order, wrapping at the frame end
      rd_col++;
      if (rd_col >= w) begin
        rd_col = 0;
        rd_row++;
        if (rd_row >= h) rd_row = 0;
      end
    endfunction

    function void check_result(out_pixel_t got);
      out_pixel_t exp_px;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0b", $time,
                 got.red, got.green, got.blue, got.last);
        errors++;
        return;
      end
      exp_px = pending_px.pop_front();
      if (got.red !== exp_px.red || got.green !== exp_px.green ||
          got.blue !== exp_px.blue || got.last !== exp_px.last) begin
        $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                 $time, exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                 got.red, got.green, got.blue, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = REG_MODE;
  logic [CFG_BITS-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    opcode_i = OP_STORE;
  chan_t                   red_in_i = '0;
  chan_t                   green_in_i = '0;
  chan_t                   blue_in_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  chan_t                   red_out_o;
  chan_t                   green_out_o;
  chan_t                   blue_out_o;
  logic                    frame_last_o;

  frame_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_stall_pct = 0;
  bit              hold_off_req = 1'b0;
  int unsigned     hold_off_left = 0;
  frame_setup_t    setups [$];

  frame_flip_grayscale_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_last_o (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[frame_flip_grayscale_engine] ERROR");
      $finish;
    end
  end

  // Drive output ready: a requested hold-off first, then random stalls
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check each output beat; signals are stable at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({red_out_o, green_out_o, blue_out_o, frame_last_o});
    end
  end

  // Offer one input beat and hold it until accepted
  task automatic send_pixel(input logic op, input chan_t r, input chan_t g, input chan_t b);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    sb.note_input(op, r, g, b);
  endtask

  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, wait for every pixel read back, then let stores finish
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] mode_val,
                           input logic [CFG_BITS-1:0] width_val,
                           input logic [CFG_BITS-1:0] height_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MODE;
    cfg_wdata_i <= mode_val;
    @(posedge clk_i);
    sb.set_reg(REG_MODE, mode_val);
    cfg_idx_i   <= REG_WIDTH;
    cfg_wdata_i <= width_val;
    @(posedge clk_i);
    sb.set_reg(REG_WIDTH, width_val);
    cfg_idx_i   <= REG_HEIGHT;
    cfg_wdata_i <= height_val;
    @(posedge clk_i);
    sb.set_reg(REG_HEIGHT, height_val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic read_pixels(input int unsigned n);
    repeat (n) send_pixel(OP_READ, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
  endtask

  // Bursts of stores and reads of random length; reads of unstored pixels become stores
  task automatic random_traffic(input int unsigned n);
    int unsigned sent, burst;
    logic        burst_op, op;
    sent = 0;
    while (sent < n) begin
      burst_op = $urandom_range(1);
      burst = $urandom_range(1, 16);
      while (burst != 0 && sent < n) begin
        op = (burst_op == OP_READ && sb.read_allowed()) ? OP_READ : OP_STORE;
        sender_gap();
        send_pixel(op, chan_t'($urandom_range(255)), chan_t'($urandom_range(255)),
                   chan_t'($urandom_range(255)));
        burst--;
        sent++;
      end
    end
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
      default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
    endcase
  endtask

  initial begin
    frame_setup_t s;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 2x2 frame with channel extremes, then every mode
    configure(MODE_GRAY, 9'd2, 9'd2);
    send_pixel(OP_STORE, 8'd0, 8'd0, 8'd0);
    send_pixel(OP_STORE, 8'd255, 8'd255, 8'd255);
    send_pixel(OP_STORE, 8'd255, 8'd0, 8'd1);
    send_pixel(OP_STORE, 8'd1, 8'd1, 8'd0);
    read_pixels(4);
    drain();
    configure(MODE_VFLIP, 9'd2, 9'd2);
    read_pixels(4);
    drain();
    configure(MODE_HFLIP, 9'd2, 9'd2);
    read_pixels(4);
    drain();
    configure(MODE_GRAY_VFLIP, 9'd2, 9'd2);
    read_pixels(2);
    drain();
    configure(MODE_GRAY_HFLIP, 9'd2, 9'd2);
    read_pixels(2);
    drain();
    // Unused mode passes pixels through
    configure(9'd7, 9'd2, 9'd2);
    read_pixels(2);

    // Hold the output off while reads keep coming, so the input backs up
    hold_off_req = 1'b1;
    read_pixels(12);
    drain();

    // Frame settings: extremes first, then random small frames
    setups.push_back('{MODE_HFLIP, 9'd3, 9'd2, 60});
    setups.push_back('{MODE_VFLIP, 9'd4, 9'd3, 60});
    setups.push_back('{MODE_GRAY_VFLIP, 9'd1, 9'd1, 40});
    setups.push_back('{MODE_GRAY_HFLIP, 9'd5, 9'd1, 50});
    setups.push_back('{MODE_GRAY, 9'd256, 9'd1, 100});
    setups.push_back('{MODE_GRAY_HFLIP, 9'd1, 9'd256, 100});
    setups.push_back('{MODE_GRAY, 9'd256, 9'd256, 60});
    setups.push_back('{9'd6, 9'd0, 9'd0, 40});
    setups.push_back('{MODE_HFLIP, 9'd2, 9'd511, 60});
    repeat (3) begin
      s.mode_val   = {6'($urandom_range(63)), 3'($urandom_range(7))};
      s.width_val  = 9'($urandom_range(1, 8));
      s.height_val = 9'($urandom_range(1, 8));
      s.items      = 50;
      setups.push_back(s);
    end

    foreach (setups[i]) begin
      set_idling(i);
      configure(setups[i].mode_val, setups[i].width_val, setups[i].height_val);
      random_traffic(setups[i].items);
      drain();
    end

    if (sb.errors == 0) begin
      $display("[frame_flip_grayscale_engine] OK");
    end else begin
      $display("[frame_flip_grayscale_engine] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/ffge_pkg.sv
src/ffge_ram.sv
src/ffge_fifo.sv
src/ffge_front.sv
src/ffge_back.sv
src/frame_flip_grayscale_engine.sv
verif/testbench.sv
